@@ rtl/tgc_pkg.sv @@
// ----------------------------------------------------------------------------
// tgc_pkg
// Types and constants shared by the tile grid collision test core and its
// iterative divider.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int COORD_W   = 16;
  localparam int DEN_W     = 16;
  localparam int NUM_W     = 23;
  localparam int CNT_W     = 7;
  localparam int DIV_CNT_W = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_POINT = 2'd1,
    REQ_BOX   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_LEFT         = 3'd0,
    CFG_MAP_TOP          = 3'd1,
    CFG_MAP_WIDTH        = 3'd2,
    CFG_MAP_HEIGHT       = 3'd3,
    CFG_GRID_COLS        = 3'd4,
    CFG_GRID_ROWS        = 3'd5,
    CFG_COLLISION_ENABLE = 3'd6
  } cfg_idx_t;

  // Edge handled by the shared divider: bit 1 selects y, bit 0 selects ceiling
  typedef enum logic [1:0] {
    PH_XL = 2'd0,
    PH_XR = 2'd1,
    PH_YT = 2'd2,
    PH_YB = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_RD,
    ST_CHK,
    ST_WRD,
    ST_WWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [NUM_W-1:0] quo;
  } div_res_t;

endpackage

@@ rtl/tgc_div.sv @@
// ----------------------------------------------------------------------------
// tgc_div
// Restoring unsigned divider, one quotient bit per cycle. Reports the
// quotient and whether the remainder is non-zero.
// ----------------------------------------------------------------------------
module tgc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tgc_pkg::NUM_W-1:0] num,
  input  logic [tgc_pkg::DEN_W-1:0] den,
  output tgc_pkg::div_res_t         res
);
  import tgc_pkg::*;

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DEN_W:0]       trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done   = done_r;
  assign res.rem_nz = |rem_r;
  assign res.quo    = quo_r;

endmodule

@@ rtl/tile_grid_collision_test_core.sv @@
// ----------------------------------------------------------------------------
// tile_grid_collision_test_core
// Blocking-bit tile grid over a world rectangle. Writes set or clear one tile; point
// and box queries map coordinates to tiles and report any blocking tile.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_wdata
//   in       in         in_valid/in_ready    in_req_type .. in_y_bottom
//   out      out        out_valid/out_ready  out_hit
//
// Write request: row read, merge, write back. Point and box requests map
// their edges through the shared divider (left and top for a point, every
// edge for a box), then scan the covered rows. After reset a clearing pass
// zeroes the map; in_ready stays low until it ends. A waiting result holds
// the core in its final state until out_ready; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tile_grid_collision_test_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgc_pkg::COORD_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [5:0]                        in_tile_col,
  input  logic [5:0]                        in_tile_row,
  input  logic                              in_tile_blocking,
  input  logic signed [tgc_pkg::COORD_W-1:0] in_x_left,
  input  logic signed [tgc_pkg::COORD_W-1:0] in_y_top,
  input  logic signed [tgc_pkg::COORD_W-1:0] in_x_right,
  input  logic signed [tgc_pkg::COORD_W-1:0] in_y_bottom,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit
);
  import tgc_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [AW-1:0]    LAST_ROW = AW'(MAX_ROWS - 1);
  localparam logic [CNT_W-1:0] MAXC     = CNT_W'(MAX_COLS);

  // configuration
  logic signed [COORD_W-1:0] map_left_r, map_top_r;
  logic [DEN_W-1:0]          map_width_r, map_height_r;
  logic [CNT_W-1:0]          grid_cols_r, grid_rows_r;
  logic                      enable_r;

  // sequencer
  state_t                    state_r, state_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [1:0]                req_r, req_nxt;
  logic [5:0]                col_r, col_nxt, row_r, row_nxt;
  logic                      blk_r, blk_nxt;
  logic signed [COORD_W-1:0] xl_r, xl_nxt, yt_r, yt_nxt, xr_r, xr_nxt, yb_r, yb_nxt;
  logic [NUM_W-1:0]          prod_r, prod_nxt;
  logic [CNT_W-1:0]          cl_r, cl_nxt, cr_r, cr_nxt, rb_r, rb_nxt;
  logic [CNT_W-1:0]          rc_r, rc_nxt;
  logic                      hit_r, hit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_hit_r, out_hit_nxt;

  // map memory
  logic [MAX_COLS-1:0]       mem [MAX_ROWS];
  logic [MAX_COLS-1:0]       rd_data_r;
  logic [AW-1:0]             mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0]       mem_wdata;
  logic                      mem_we;

  // datapath
  logic [CNT_W-1:0]          used_cols, used_rows, cnt_sel;
  logic                      live, contain, overlap, wr_ok;
  logic signed [COORD_W:0]   dx, dy, diff;
  logic signed [COORD_W+1:0] mr, mb;
  logic signed [COORD_W-1:0] coord_sel, base_sel;
  logic [COORD_W-1:0]        diff_u;
  logic [DEN_W-1:0]          den_sel;
  logic [NUM_W:0]            q_adj;
  logic [CNT_W-1:0]          qc;
  logic [MAX_COLS-1:0]       col_mask, wr_mask;
  logic                      row_hit;
  logic                      div_start;
  div_res_t                  div_res;

  tgc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (den_sel),
    .res   (div_res)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign div_start = (state_r == ST_DIVS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_left_r   <= '0;
      map_top_r    <= '0;
      map_width_r  <= DEN_W'(1);
      map_height_r <= DEN_W'(1);
      grid_cols_r  <= CNT_W'(64);
      grid_rows_r  <= CNT_W'(64);
      enable_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_LEFT:         map_left_r   <= cfg_wdata;
        CFG_MAP_TOP:          map_top_r    <= cfg_wdata;
        CFG_MAP_WIDTH:        map_width_r  <= cfg_wdata;
        CFG_MAP_HEIGHT:       map_height_r <= cfg_wdata;
        CFG_GRID_COLS:        grid_cols_r  <= cfg_wdata[CNT_W-1:0];
        CFG_GRID_ROWS:        grid_rows_r  <= cfg_wdata[CNT_W-1:0];
        CFG_COLLISION_ENABLE: enable_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign used_cols = (grid_cols_r < MAXC) ? grid_cols_r : MAXC;
  assign used_rows = (int'(grid_rows_r) < MAX_ROWS) ? grid_rows_r : CNT_W'(MAX_ROWS);
  assign live      = enable_r && (map_width_r != '0) && (map_height_r != '0)
                     && (used_cols != '0) && (used_rows != '0);

  assign dx      = {xl_r[COORD_W-1], xl_r} - {map_left_r[COORD_W-1], map_left_r};
  assign dy      = {yt_r[COORD_W-1], yt_r} - {map_top_r[COORD_W-1], map_top_r};
  assign contain = !dx[COORD_W] && (dx[COORD_W-1:0] < map_width_r)
                   && !dy[COORD_W] && (dy[COORD_W-1:0] < map_height_r);

  assign mr      = {{2{map_left_r[COORD_W-1]}}, map_left_r} + {2'b00, map_width_r};
  assign mb      = {{2{map_top_r[COORD_W-1]}}, map_top_r} + {2'b00, map_height_r};
  assign overlap = ($signed({{2{xl_r[COORD_W-1]}}, xl_r}) < mr) && (map_left_r < xr_r)
                   && ($signed({{2{yt_r[COORD_W-1]}}, yt_r}) < mb) && (map_top_r < yb_r);

  assign wr_ok = ({1'b0, col_r} < MAXC) && (int'(row_r) < MAX_ROWS);

  always_comb begin
    case (phase_r)
      PH_XL:   coord_sel = xl_r;
      PH_XR:   coord_sel = xr_r;
      PH_YT:   coord_sel = yt_r;
      PH_YB:   coord_sel = yb_r;
      default: coord_sel = xl_r;
    endcase
  end

  assign base_sel = phase_r[1] ? map_top_r : map_left_r;
  assign cnt_sel  = phase_r[1] ? used_rows : used_cols;
  assign den_sel  = phase_r[1] ? map_height_r : map_width_r;
  assign diff     = {coord_sel[COORD_W-1], coord_sel} - {base_sel[COORD_W-1], base_sel};
  // negative edges clamp to tile zero for either rounding
  assign diff_u   = diff[COORD_W] ? '0 : diff[COORD_W-1:0];

  assign q_adj = {1'b0, div_res.quo} + (NUM_W+1)'(phase_r[0] && div_res.rem_nz);
  assign qc    = (q_adj > (NUM_W+1)'(cnt_sel)) ? cnt_sel : q_adj[CNT_W-1:0];

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (CNT_W'(c) >= cl_r) && (CNT_W'(c) < cr_r);
      wr_mask[c]  = ({1'b0, col_r} == CNT_W'(c));
    end
  end

  assign row_hit = |(rd_data_r & col_mask);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    blk_nxt       = blk_r;
    xl_nxt        = xl_r;
    yt_nxt        = yt_r;
    xr_nxt        = xr_r;
    yb_nxt        = yb_r;
    prod_nxt      = prod_r;
    cl_nxt        = cl_r;
    cr_nxt        = cr_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    mem_raddr     = AW'(rc_r);
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_we        = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          col_nxt   = in_tile_col;
          row_nxt   = in_tile_row;
          blk_nxt   = in_tile_blocking;
          xl_nxt    = in_x_left;
          yt_nxt    = in_y_top;
          xr_nxt    = in_x_right;
          yb_nxt    = in_y_bottom;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        hit_nxt   = 1'b0;
        phase_nxt = PH_XL;
        state_nxt = ST_DONE;
        case (req_r)
          REQ_WRITE: if (wr_ok) state_nxt = ST_WRD;
          REQ_POINT: if (live && contain) state_nxt = ST_MUL;
          REQ_BOX:   if (live && overlap) state_nxt = ST_MUL;
          default: ;
        endcase
      end
      ST_MUL: begin
        prod_nxt  = {{(NUM_W-COORD_W){1'b0}}, diff_u} * {{(NUM_W-CNT_W){1'b0}}, cnt_sel};
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_res.done) begin
          state_nxt = ST_MUL;
          case (phase_r)
            PH_XL: begin
              cl_nxt = qc;
              if (req_r == REQ_POINT) begin
                cr_nxt    = qc + 1'b1;
                phase_nxt = PH_YT;
              end else begin
                phase_nxt = PH_XR;
              end
            end
            PH_XR: begin
              cr_nxt    = qc;
              phase_nxt = PH_YT;
            end
            PH_YT: begin
              rc_nxt = qc;
              if (req_r == REQ_POINT) begin
                rb_nxt    = qc + 1'b1;
                state_nxt = ST_RD;
              end else begin
                phase_nxt = PH_YB;
              end
            end
            PH_YB: begin
              rb_nxt    = qc;
              state_nxt = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        mem_raddr = AW'(rc_r);
        state_nxt = (rc_r < rb_r) ? ST_CHK : ST_DONE;
      end
      ST_CHK: begin
        if (row_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rc_nxt    = rc_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_WRD: begin
        mem_raddr = AW'(row_r);
        state_nxt = ST_WWR;
      end
      ST_WWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(row_r);
        mem_wdata = (rd_data_r & ~wr_mask) | (blk_r ? wr_mask : '0);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r   <= phase_nxt;
    req_r     <= req_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    blk_r     <= blk_nxt;
    xl_r      <= xl_nxt;
    yt_r      <= yt_nxt;
    xr_r      <= xr_nxt;
    yb_r      <= yb_nxt;
    prod_r    <= prod_nxt;
    cl_r      <= cl_nxt;
    cr_r      <= cr_nxt;
    rb_r      <= rb_nxt;
    rc_r      <= rc_nxt;
    hit_r     <= hit_nxt;
    out_hit_r <= out_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |-> (rc_r < rb_r))
    else $error("row scan beyond the covered rows");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIVW))
    else $error("divider finished while not awaited");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished request not delivered");
`endif

endmodule
